FILE: rtl/core/cgbw_pkg.sv
// Package for the clipped glyph blit writer: widths, register indexes,
// the depth code and the structs passed between the pipeline modules.
// Depends on nothing; every other file of the block uses it.
package cgbw_pkg;

    // Largest screen side and glyph side that the block handles.
    localparam int MAX_SCREEN_SIDE = 4096;
    localparam int MAX_GLYPH_SIDE  = 256;

    // Fixed field widths of the ports.
    localparam int CFG_W       = 13;   // widest register, origins and screen sides
    localparam int GLYPH_CFG_W = 9;    // glyph size registers
    localparam int BPP_W       = 6;    // depth register
    localparam int IDX_W       = 3;    // register index
    localparam int COLOR_W     = 32;
    localparam int ADDR_W      = 26;
    localparam int BYTES_W     = 3;

    // Internal widths.
    localparam int SIDE_W  = $clog2(MAX_SCREEN_SIDE) + 1;  // clamped screen side
    localparam int POS_W   = $clog2(MAX_SCREEN_SIDE);      // on-screen coordinate
    localparam int GSIDE_W = $clog2(MAX_GLYPH_SIDE) + 1;   // clamped glyph side
    localparam int CNT_W   = $clog2(MAX_GLYPH_SIDE);       // column and row counters
    localparam int COORD_W = CFG_W + 1;                    // origin plus counter, signed

    // Supported depths in bits per pixel.
    localparam logic [BPP_W-1:0] BPP_8  = BPP_W'(8);
    localparam logic [BPP_W-1:0] BPP_16 = BPP_W'(16);
    localparam logic [BPP_W-1:0] BPP_32 = BPP_W'(32);

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_GLYPH_WIDTH   = 3'd2,
        REG_GLYPH_ROWS    = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_BITS_PER_PIX  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        DEPTH_8,
        DEPTH_16,
        DEPTH_32,
        DEPTH_NONE
    } t_depth;

    // Configuration as the datapath sees it: sides already clamped.
    typedef struct packed {
        logic [CFG_W-1:0]   origin_x;
        logic [CFG_W-1:0]   origin_y;
        logic [GSIDE_W-1:0] glyph_width;
        logic [GSIDE_W-1:0] glyph_rows;
        logic [SIDE_W-1:0]  screen_width;
        logic [SIDE_W-1:0]  screen_height;
        t_depth             depth;
    } t_cfg;

    // One pixel after the position stage.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               we;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic               done;
    } t_pix;

endpackage

FILE: rtl/core/cgbw_if.sv
// Channel interfaces of the clipped glyph blit writer: pixel input,
// framebuffer write output and register write port. Depends on cgbw_pkg.
interface cgbw_in_if;
    logic                           valid;
    logic                           ready;
    logic [cgbw_pkg::COLOR_W-1:0]   pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

interface cgbw_out_if;
    logic                           valid;
    logic                           ready;
    logic                           write_enable;
    logic [cgbw_pkg::ADDR_W-1:0]    write_address;
    logic [cgbw_pkg::COLOR_W-1:0]   write_data;
    logic [cgbw_pkg::BYTES_W-1:0]   write_bytes;
    logic                           glyph_done;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, output write_bytes, output glyph_done,
                    input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_data, input write_bytes, input glyph_done,
                    output ready);
endinterface

interface cgbw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cgbw_pkg::IDX_W-1:0]     index;
    logic [cgbw_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/clipped_glyph_blit_writer_unit.sv
// Top level of the clipped glyph blit writer: register file, position stage
// and write stage. Depends on cgbw_pkg, cgbw_if, cgbw_cfg, cgbw_pos and cgbw_wr.
//
// The block turns a stream of glyph pixels, given in raster order on i_pix,
// into framebuffer write words on o_wr. Each accepted pixel word yields
// exactly one write word: the byte offset, the data packed for the depth,
// the byte count, a write enable that is low for clipped pixels or an
// unsupported depth, and glyph_done on the last pixel of the glyph.
// Registers are written through i_cfg, which is always ready; they should
// only be changed while no pixel is in flight.
// An accepted pixel sits in the position register, and its write word is then
// registered in the output register, which drives o_wr. The block takes one
// pixel per cycle while o_wr.ready stays high; the y * screen_width multiplier
// of the write stage is the longest path.
// When the receiver stalls, the write word is held in the output register and
// the position register can still take one more pixel before i_pix.ready
// falls. Reset clears the counters, the stage valid bits and the registers
// to their defaults (origin 0, sides 1, 32 bits per pixel).
module clipped_glyph_blit_writer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgbw_in_if.sink     i_pix,
    cgbw_cfg_if.sink    i_cfg,
    cgbw_out_if.source  o_wr
);
    import cgbw_pkg::*;

    t_cfg cfg;
    t_pix s1;
    logic s1_valid;
    logic s2_ready;

    // Register file: holds the clamped sides and the decoded depth.
    cgbw_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (i_cfg),
        .o_cfg    (cfg)
    );

    // First stage: counters, screen position and clipping.
    cgbw_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_pix      (i_pix),
        .i_s2_ready (s2_ready),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    // Second stage: byte offset and pixel packing into the output register.
    cgbw_wr u_wr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s2_ready (s2_ready),
        .o_wr       (o_wr)
    );

endmodule

FILE: rtl/core/cgbw_cfg.sv
// Register file of the clipped glyph blit writer; sides are clamped and the
// depth decoded as each word is written. Depends on cgbw_pkg and cgbw_if.
module cgbw_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cgbw_cfg_if.sink        i_cfg_wr,
    output cgbw_pkg::t_cfg  o_cfg
);
    import cgbw_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_fire;

    function automatic logic [GSIDE_W-1:0] clamp_glyph(input logic [GLYPH_CFG_W-1:0] raw);
        logic [GSIDE_W-1:0] res;
        if (raw == '0) begin
            res = GSIDE_W'(1);
        end else if (32'(raw) > 32'(MAX_GLYPH_SIDE)) begin
            res = GSIDE_W'(MAX_GLYPH_SIDE);
        end else begin
            res = GSIDE_W'(raw);
        end
        return res;
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_screen(input logic [CFG_W-1:0] raw);
        logic [SIDE_W-1:0] res;
        if (raw == '0) begin
            res = SIDE_W'(1);
        end else if (32'(raw) > 32'(MAX_SCREEN_SIDE)) begin
            res = SIDE_W'(MAX_SCREEN_SIDE);
        end else begin
            res = SIDE_W'(raw);
        end
        return res;
    endfunction

    function automatic t_depth decode_depth(input logic [BPP_W-1:0] raw);
        t_depth res;
        if (raw == BPP_8) begin
            res = DEPTH_8;
        end else if (raw == BPP_16) begin
            res = DEPTH_16;
        end else if (raw == BPP_32) begin
            res = DEPTH_32;
        end else begin
            res = DEPTH_NONE;
        end
        return res;
    endfunction

    assign i_cfg_wr.ready = 1'b1;
    assign wr_fire        = i_cfg_wr.valid && i_cfg_wr.ready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_fire) begin
            unique case (i_cfg_wr.index)
                REG_ORIGIN_X:      n_cfg.origin_x      = i_cfg_wr.data;
                REG_ORIGIN_Y:      n_cfg.origin_y      = i_cfg_wr.data;
                REG_GLYPH_WIDTH:   n_cfg.glyph_width   =
                    clamp_glyph(i_cfg_wr.data[GLYPH_CFG_W-1:0]);
                REG_GLYPH_ROWS:    n_cfg.glyph_rows    =
                    clamp_glyph(i_cfg_wr.data[GLYPH_CFG_W-1:0]);
                REG_SCREEN_WIDTH:  n_cfg.screen_width  = clamp_screen(i_cfg_wr.data);
                REG_SCREEN_HEIGHT: n_cfg.screen_height = clamp_screen(i_cfg_wr.data);
                REG_BITS_PER_PIX:  n_cfg.depth         =
                    decode_depth(i_cfg_wr.data[BPP_W-1:0]);
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.glyph_width   <= GSIDE_W'(1);
            r_cfg.glyph_rows    <= GSIDE_W'(1);
            r_cfg.screen_width  <= SIDE_W'(1);
            r_cfg.screen_height <= SIDE_W'(1);
            r_cfg.depth         <= DEPTH_32;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/cgbw_pos.sv
// Position stage: column and row counters, screen position, clipping and
// the end-of-row and end-of-glyph flags. Depends on cgbw_pkg and cgbw_if.
module cgbw_pos (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cgbw_pkg::t_cfg  i_cfg,
    cgbw_in_if.sink         i_pix,
    input  logic            i_s2_ready,
    output logic            o_s1_valid,
    output cgbw_pkg::t_pix  o_s1
);
    import cgbw_pkg::*;

    logic [CNT_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_row;
    logic               r_s1_valid;
    t_pix               r_s1;
    logic [CNT_W-1:0]   n_col;
    logic [CNT_W-1:0]   n_row;
    logic               n_s1_valid;
    t_pix               n_s1;

    logic               accept;
    logic [CNT_W:0]     col_inc;
    logic [CNT_W:0]     row_inc;
    logic               row_end;
    logic               done;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on_x;
    logic               on_y;

    assign i_pix.ready = !r_s1_valid || i_s2_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    // A counter at or past the glyph side also counts as at its end, so a width that
    // shrinks mid-glyph ends the row at once, and fewer rows end the glyph with the row.
    assign col_inc = {1'b0, r_col} + (CNT_W + 1)'(1);
    assign row_inc = {1'b0, r_row} + (CNT_W + 1)'(1);
    assign row_end = GSIDE_W'(col_inc) >= i_cfg.glyph_width;
    assign done    = row_end && (GSIDE_W'(row_inc) >= i_cfg.glyph_rows);

    assign x = {i_cfg.origin_x[CFG_W-1], i_cfg.origin_x} + COORD_W'(r_col);
    assign y = {i_cfg.origin_y[CFG_W-1], i_cfg.origin_y} + COORD_W'(r_row);

    assign on_x = !x[COORD_W-1] && (32'(x) < 32'(i_cfg.screen_width));
    assign on_y = !y[COORD_W-1] && (32'(y) < 32'(i_cfg.screen_height));

    always_comb begin
        n_s1.color = i_pix.pixel_color;
        n_s1.we    = on_x && on_y && (i_cfg.depth != DEPTH_NONE);
        n_s1.x     = x[POS_W-1:0];
        n_s1.y     = y[POS_W-1:0];
        n_s1.done  = done;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (done) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = row_inc[CNT_W-1:0];
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (i_s2_ready) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

`ifndef ASSERT_OFF
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && done |=> (r_col == '0) && (r_row == '0))
        else $error("counters not cleared after the last pixel of a glyph");

    a_col_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !row_end |=> (r_col == $past(col_inc[CNT_W-1:0])) && $stable(r_row))
        else $error("column counter did not step within a row");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_s2_ready |=> r_s1_valid && $stable(r_s1))
        else $error("position stage lost or changed a stalled pixel");
`endif

endmodule

FILE: rtl/core/cgbw_wr.sv
// Write stage: byte offset from the clipped position, pixel packing by depth
// and the output register of the write channel. Depends on cgbw_pkg and cgbw_if.
module cgbw_wr (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cgbw_pkg::t_cfg  i_cfg,
    input  logic            i_s1_valid,
    input  cgbw_pkg::t_pix  i_s1,
    output logic            o_s2_ready,
    cgbw_out_if.source      o_wr
);
    import cgbw_pkg::*;

    localparam int PROD_W = POS_W + SIDE_W;
    localparam int LIN_W  = PROD_W + 1;

    logic                   r_valid;
    logic                   r_we;
    logic [ADDR_W-1:0]      r_addr;
    logic [COLOR_W-1:0]     r_data;
    logic [BYTES_W-1:0]     r_bytes;
    logic                   r_done;
    logic                   n_valid;
    logic [ADDR_W-1:0]      n_addr;
    logic [COLOR_W-1:0]     n_data;
    logic [BYTES_W-1:0]     n_bytes;

    logic                   load;
    logic [PROD_W-1:0]      prod;
    logic [LIN_W-1:0]       lin;

    assign o_s2_ready = !r_valid || o_wr.ready;
    assign load       = i_s1_valid && o_s2_ready;

    // Pixel index in the framebuffer; the depth turns it into bytes by a shift.
    assign prod = PROD_W'(i_s1.y) * PROD_W'(i_cfg.screen_width);
    assign lin  = LIN_W'(prod) + LIN_W'(i_s1.x);

    always_comb begin
        n_addr  = '0;
        n_data  = '0;
        n_bytes = BYTES_W'(1);
        if (i_s1.we) begin
            case (i_cfg.depth)
                DEPTH_8: begin
                    n_addr  = ADDR_W'(lin);
                    n_data  = COLOR_W'(i_s1.color[7:0]);
                    n_bytes = BYTES_W'(1);
                end
                DEPTH_16: begin
                    n_addr  = ADDR_W'({lin, 1'b0});
                    n_data  = COLOR_W'({i_s1.color[23:19], i_s1.color[15:10],
                                        i_s1.color[7:3]});
                    n_bytes = BYTES_W'(2);
                end
                DEPTH_32: begin
                    n_addr  = ADDR_W'({lin, 2'b00});
                    n_data  = i_s1.color;
                    n_bytes = BYTES_W'(4);
                end
                default: begin
                    n_addr  = '0;
                    n_data  = '0;
                    n_bytes = BYTES_W'(1);
                end
            endcase
        end
    end

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (o_wr.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_we    <= i_s1.we;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_bytes <= n_bytes;
            r_done  <= i_s1.done;
        end
    end

    assign o_wr.valid         = r_valid;
    assign o_wr.write_enable  = r_we;
    assign o_wr.write_address = r_addr;
    assign o_wr.write_data    = r_data;
    assign o_wr.write_bytes   = r_bytes;
    assign o_wr.glyph_done    = r_done;

`ifndef ASSERT_OFF
    a_idle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_we |-> (r_addr == '0) && (r_data == '0) && (r_bytes == BYTES_W'(1)))
        else $error("disabled write carries a non-zero address, data or size");

    a_bytes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_we |-> (r_bytes == BYTES_W'(1)) || (r_bytes == BYTES_W'(2))
                            || (r_bytes == BYTES_W'(4)))
        else $error("enabled write with an illegal byte count");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_valid)
        else $error("write stage dropped a loaded pixel");

    a_565_high_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_we && (r_bytes == BYTES_W'(2)) |-> (r_data[COLOR_W-1:16] == '0))
        else $error("16 bpp write with data above the low half-word");
`endif

endmodule
